[src/barp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barp_pkg
// Shared types, constants and elaboration-time tables for the ancestry
// rank probability block.
// ----------------------------------------------------------------------------
package barp_pkg;

  localparam int unsigned CNT_CEIL  = 1023;
  localparam int unsigned TAB_SIZE  = 4 * CNT_CEIL + 4;
  localparam int unsigned TAB_AW    = $clog2(TAB_SIZE);
  localparam int unsigned TAB_W     = 40;
  localparam int unsigned LOG_EW    = $clog2(TAB_AW);
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned ARG_W     = CNT_W + 1;
  localparam int unsigned SUM_W     = ARG_W + 2;
  localparam int unsigned E_W       = 44;
  localparam int unsigned TERM_W    = 45;
  localparam int unsigned PROB_W    = 33;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned ACC_W     = 64;

  localparam logic [27:0] LN2_Q28     = 28'd186065280;
  localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;

  localparam logic [PROB_W-1:0]       ONE_Q32   = 33'h1_0000_0000;
  localparam logic signed [ACC_W-1:0] ONE_Q32_W = 64'sh1_0000_0000;
  localparam logic signed [ACC_W-1:0] HALF_Q32  = 64'sh8000_0000;

  localparam logic signed [E_W-1:0] E_HI = 44'sd134217728;
  localparam logic signed [E_W-1:0] E_LO = -44'sd536870912;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_RANK = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  typedef logic [31:0] root_arr_t [31];

  typedef struct packed {
    logic [CNT_W-1:0] alt_p;
    logic [CNT_W-1:0] ref_p;
    logic [CNT_W-1:0] alt_q;
    logic [CNT_W-1:0] ref_q;
  } sample_t;

  typedef struct packed {
    logic              valid;
    logic [PROB_W-1:0] prob;
    logic [1:0]        status;
  } sel_result_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-i) in q30, each from the integer square root of the previous one
  function automatic root_arr_t build_roots();
    root_arr_t t;
    t[0] = 32'h8000_0000;
    for (int i = 1; i <= 30; i++) begin
      t[i] = 32'(isqrt64({32'd0, t[i-1]} << 30));
    end
    return t;
  endfunction

  localparam root_arr_t ROOT = build_roots();

endpackage

[src/barp_lfact_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barp_lfact_table
// Log-factorial memory in q15.24. After reset it fills itself entry by
// entry, forming log2(k) by repeated squaring, then serves one read port.
// ----------------------------------------------------------------------------
module barp_lfact_table import barp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [TAB_AW-1:0]        rd_addr_i,
  output logic signed [TAB_W-1:0]  rd_data_o,
  output logic                     ready_o
);

  typedef enum logic [2:0] {
    F_ZERO, F_NORM, F_SQ, F_MUL, F_ACC, F_WR, F_DONE
  } fill_e;

  fill_e               state_q, state_d;
  logic [TAB_AW-1:0]   k_q, k_d;
  logic [LOG_EW-1:0]   e_q, e_d;
  logic [30:0]         m_q, m_d;
  logic [31:0]         frac_q, frac_d;
  logic [4:0]          it_q, it_d;
  logic [63:0]         prod_q, prod_d;
  logic [47:0]         acc_q, acc_d;

  logic [TAB_W-1:0]    mem [TAB_SIZE];
  logic [TAB_W-1:0]    rd_q;
  logic                wr_en;
  logic [TAB_AW-1:0]   wr_addr;
  logic [TAB_W-1:0]    wr_data;

  logic [LOG_EW-1:0]   msb;
  logic [61:0]         sq;
  logic [31:0]         sq_t;
  logic [48:0]         acc_rnd;
  logic [64:0]         prod_rnd;

  always_comb begin
    msb = '0;
    for (int b = 0; b < TAB_AW; b++) begin
      if (k_q[b]) msb = LOG_EW'(b);
    end
  end

  assign sq       = 62'(m_q) * 62'(m_q);
  assign sq_t     = sq[61:30];
  assign prod_rnd = 65'(prod_q) + 65'(64'd1 << 27);
  assign acc_rnd  = 49'(acc_q) + 49'd128;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    e_d     = e_q;
    m_d     = m_q;
    frac_d  = frac_q;
    it_d    = it_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    case (state_q)
      F_ZERO: begin
        k_d     = TAB_AW'(1);
        acc_d   = '0;
        state_d = F_NORM;
      end
      F_NORM: begin
        e_d     = msb;
        m_d     = 31'(31'(k_q) << (5'd30 - 5'(msb)));
        frac_d  = '0;
        it_d    = '0;
        state_d = F_SQ;
      end
      F_SQ: begin
        frac_d = {frac_q[30:0], sq_t[31]};
        m_d    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) state_d = F_MUL;
      end
      F_MUL: begin
        prod_d  = 64'({e_q, frac_q}) * 64'(LN2_Q28);
        state_d = F_ACC;
      end
      F_ACC: begin
        acc_d   = acc_q + 48'(prod_rnd >> 28);
        state_d = F_WR;
      end
      F_WR: begin
        if (k_q == TAB_AW'(TAB_SIZE - 1)) begin
          state_d = F_DONE;
        end else begin
          k_d     = k_q + TAB_AW'(1);
          state_d = F_NORM;
        end
      end
      F_DONE: state_d = F_DONE;
      default: state_d = F_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_ZERO;
      k_q     <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign wr_en   = (state_q == F_ZERO) || (state_q == F_WR);
  assign wr_addr = (state_q == F_ZERO) ? '0 : k_q;
  assign wr_data = (state_q == F_ZERO) ? '0 : acc_rnd[TAB_W+7:8];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = $signed(rd_q);
  assign ready_o   = (state_q == F_DONE);

endmodule

[src/barp_exp_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barp_exp_unit
// Iterative exp of a q24 exponent, result in q32. One root-constant
// multiply per cycle builds 2^fraction.
// ----------------------------------------------------------------------------
module barp_exp_unit import barp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [E_W-1:0] e_i,
  output logic                  done_o,
  output logic [TERM_W-1:0]     term_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SPLIT, S_POW, S_SCALE
  } state_e;

  state_e              state_q;
  logic                neg_q;
  logic [29:0]         mag_q;
  logic [36:0]         w_q;
  logic [6:0]          ip_q;
  logic [29:0]         f_q;
  logic [30:0]         m_q;
  logic [4:0]          i_q;
  logic [TERM_W-1:0]   term_q;
  logic                done_q;

  logic signed [E_W-1:0] ec;
  logic [E_W-1:0]        mag_full;
  logic [60:0]           wprod;
  logic [61:0]           pprod;
  logic [7:0]            shl, shr;
  logic                  left;
  logic [63:0]           rsum;
  logic [63:0]           scaled;

  always_comb begin
    if (e_i > E_HI)      ec = E_HI;
    else if (e_i < E_LO) ec = E_LO;
    else                 ec = e_i;
    mag_full = (ec < 0) ? E_W'(-ec) : E_W'(ec);
  end

  assign wprod = 61'(mag_q) * 61'(INV_LN2_Q30);
  assign pprod = 62'(m_q) * 62'(ROOT[i_q][30:0]) + 62'(62'd1 << 29);

  always_comb begin
    shl  = 8'(ip_q) + 8'd2;
    shr  = 8'(ip_q) - 8'd2;
    left = 1'b1;
    if (neg_q) begin
      if (ip_q <= 7'd2) shl = 8'd2 - 8'(ip_q);
      else              left = 1'b0;
    end
    rsum = 64'(m_q) + (64'd1 << (shr - 8'd1));
    if (left)              scaled = 64'(m_q) << shl;
    else if (shr >= 8'd62) scaled = '0;
    else                   scaled = rsum >> shr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            neg_q   <= (ec < 0);
            mag_q   <= mag_full[29:0];
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          w_q     <= wprod[60:24];
          state_q <= S_SPLIT;
        end
        S_SPLIT: begin
          // negative exponent: round the integer part up, mirror the fraction
          if (neg_q && (w_q[29:0] != '0)) begin
            ip_q <= w_q[36:30] + 7'd1;
            f_q  <= 30'(31'h4000_0000 - 31'(w_q[29:0]));
          end else begin
            ip_q <= w_q[36:30];
            f_q  <= w_q[29:0];
          end
          m_q     <= 31'h4000_0000;
          i_q     <= 5'd1;
          state_q <= S_POW;
        end
        S_POW: begin
          if (f_q[5'd30 - i_q]) m_q <= pprod[60:30];
          i_q <= i_q + 5'd1;
          if (i_q == 5'd30) state_q <= S_SCALE;
        end
        S_SCALE: begin
          term_q  <= scaled[TERM_W-1:0];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign term_o = term_q;

endmodule

[src/barp_term_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barp_term_engine
// Per-sample probability: walks the four closed-form sums term by term,
// reading eleven table entries for each exponent and summing the exps.
// ----------------------------------------------------------------------------
module barp_term_engine import barp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  sample_t                  sample_i,
  output logic [TAB_AW-1:0]        rd_addr_o,
  input  logic signed [TAB_W-1:0]  rd_data_i,
  output logic                     done_o,
  output logic [PROB_W-1:0]        prob_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_READ, S_EXP, S_WAIT, S_FIN, S_DONE
  } state_e;

  typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_D} phase_e;

  state_e                  state_q;
  phase_e                  phase_q;
  logic [ARG_W-1:0]        a_q, b_q, c_q, d_q;
  logic [ARG_W-1:0]        aa_q, bb_q, cc_q, dd_q, n_q;
  logic signed [ACC_W-1:0] res_q;
  logic signed [E_W-1:0]   eacc_q;
  logic [3:0]              ri_q;
  logic [PROB_W-1:0]       prob_q;
  logic                    done_q;

  logic [ARG_W-1:0]        a_in, b_in, c_in, d_in;
  logic                    pz, qz;
  logic [SUM_W-1:0]        s_ac, s_bd, s_ab, s_cd, s_all, addr_w;
  logic [3:0]              rprev;
  logic                    add_prev;
  logic signed [E_W-1:0]   rd_ext;
  logic                    exp_done;
  logic [TERM_W-1:0]       term;
  logic signed [ACC_W-1:0] term_ext, diff;

  assign a_in = ARG_W'(sample_i.alt_q) + ARG_W'(1);
  assign b_in = ARG_W'(sample_i.ref_q) + ARG_W'(1);
  assign c_in = ARG_W'(sample_i.alt_p) + ARG_W'(1);
  assign d_in = ARG_W'(sample_i.ref_p) + ARG_W'(1);
  assign pz   = (sample_i.alt_p == '0) && (sample_i.ref_p == '0);
  assign qz   = (sample_i.alt_q == '0) && (sample_i.ref_q == '0);

  assign s_ac  = SUM_W'(aa_q) + SUM_W'(cc_q);
  assign s_bd  = SUM_W'(bb_q) + SUM_W'(dd_q);
  assign s_ab  = SUM_W'(aa_q) + SUM_W'(bb_q);
  assign s_cd  = SUM_W'(cc_q) + SUM_W'(dd_q);
  assign s_all = s_ac + s_bd;

  always_comb begin
    case (ri_q)
      4'd0:    addr_w = s_ac - SUM_W'(1);
      4'd1:    addr_w = s_bd - SUM_W'(1);
      4'd2:    addr_w = s_all - SUM_W'(1);
      4'd3:    addr_w = SUM_W'(aa_q) - SUM_W'(1);
      4'd4:    addr_w = SUM_W'(bb_q) - SUM_W'(1);
      4'd5:    addr_w = s_ab - SUM_W'(1);
      4'd6:    addr_w = SUM_W'(cc_q) - SUM_W'(1);
      4'd7:    addr_w = SUM_W'(dd_q) - SUM_W'(1);
      4'd8:    addr_w = s_cd - SUM_W'(1);
      4'd9:    addr_w = SUM_W'(n_q);
      4'd10:   addr_w = SUM_W'(n_q) - SUM_W'(1);
      default: addr_w = '0;
    endcase
  end

  assign rd_addr_o = addr_w[TAB_AW-1:0];

  // lbeta of the joint pair minus both lbetas minus ln(n)
  assign rprev = ri_q - 4'd1;
  always_comb begin
    case (rprev)
      4'd0, 4'd1, 4'd5, 4'd8, 4'd10: add_prev = 1'b1;
      default:                       add_prev = 1'b0;
    endcase
  end

  assign rd_ext   = {{(E_W-TAB_W){rd_data_i[TAB_W-1]}}, rd_data_i};
  assign term_ext = $signed({{(ACC_W-TERM_W){1'b0}}, term});
  assign diff     = ONE_Q32_W - res_q;

  barp_exp_unit u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_EXP),
    .e_i     (eacc_q),
    .done_o  (exp_done),
    .term_o  (term)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      ri_q    <= '0;
      phase_q <= PH_A;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a_q   <= a_in;
            b_q   <= b_in;
            c_q   <= c_in;
            d_q   <= d_in;
            aa_q  <= (a_in < c_in) ? a_in : c_in;
            bb_q  <= (b_in < d_in) ? b_in : d_in;
            cc_q  <= (a_in < c_in) ? a_in : c_in;
            dd_q  <= (b_in < d_in) ? b_in : d_in;
            res_q <= HALF_Q32;
            if (pz && qz) begin
              prob_q  <= ONE_Q32;
              state_q <= S_DONE;
            end else if (pz) begin
              prob_q  <= '0;
              state_q <= S_DONE;
            end else if (qz) begin
              prob_q  <= ONE_Q32;
              state_q <= S_DONE;
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          ri_q    <= '0;
          eacc_q  <= '0;
          state_q <= S_READ;
          if (aa_q < a_q) begin
            phase_q <= PH_A;
            n_q     <= aa_q;
          end else if (bb_q < b_q) begin
            phase_q <= PH_B;
            n_q     <= bb_q;
          end else if (cc_q < c_q) begin
            phase_q <= PH_C;
            n_q     <= cc_q;
          end else if (dd_q < d_q) begin
            phase_q <= PH_D;
            n_q     <= dd_q;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_READ: begin
          if (ri_q != 4'd0) begin
            eacc_q <= add_prev ? eacc_q + rd_ext : eacc_q - rd_ext;
          end
          ri_q <= ri_q + 4'd1;
          if (ri_q == 4'd11) state_q <= S_EXP;
        end
        S_EXP: state_q <= S_WAIT;
        S_WAIT: begin
          if (exp_done) begin
            case (phase_q)
              PH_A: begin
                res_q <= res_q + term_ext;
                aa_q  <= aa_q + ARG_W'(1);
              end
              PH_B: begin
                res_q <= res_q - term_ext;
                bb_q  <= bb_q + ARG_W'(1);
              end
              PH_C: begin
                res_q <= res_q - term_ext;
                cc_q  <= cc_q + ARG_W'(1);
              end
              PH_D: begin
                res_q <= res_q + term_ext;
                dd_q  <= dd_q + ARG_W'(1);
              end
              default: res_q <= res_q;
            endcase
            state_q <= S_NEXT;
          end
        end
        S_FIN: begin
          if (diff < 0)              prob_q <= '0;
          else if (diff > ONE_Q32_W) prob_q <= ONE_Q32;
          else                       prob_q <= diff[PROB_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prob_o = prob_q;

endmodule

[src/barp_rank_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barp_rank_select
// Probability buffer memory with sample count and overflow flag. On the
// last sample it finds the requested rank by counting, per candidate,
// the smaller and equal entries.
// ----------------------------------------------------------------------------
module barp_rank_select import barp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               store_i,
  input  logic [PROB_W-1:0]  prob_i,
  input  logic               last_i,
  input  logic [RANK_W-1:0]  order_rank_i,
  output logic               finish_o,
  output sel_result_t        result_o
);

  localparam int unsigned SC_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CMP_W = ((SC_W > RANK_W) ? SC_W : RANK_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RDI, S_LDI, S_RDJ, S_CMPJ, S_EVAL
  } state_e;

  state_e             state_q;
  logic [SC_W-1:0]    cnt_q;
  logic               ovf_q;
  logic [SC_W-1:0]    i_q, j_q, less_q, eq_q;
  logic [PROB_W-1:0]  vi_q;
  logic               fin_q;
  sel_result_t        res_q;

  logic [PROB_W-1:0]  mem [MAX_SAMPLES];
  logic [PROB_W-1:0]  rd_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [CMP_W-1:0]   rank_x, less_x, span_x, cnt_x;

  assign wr_en   = (state_q == S_IDLE) && store_i && (cnt_q < SC_W'(MAX_SAMPLES));
  assign rd_addr = (state_q == S_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[AW-1:0]] <= prob_i;
    rd_q <= mem[rd_addr];
  end

  assign rank_x = CMP_W'(order_rank_i);
  assign less_x = CMP_W'(less_q);
  assign span_x = CMP_W'(less_q) + CMP_W'(eq_q);
  assign cnt_x  = CMP_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      ovf_q         <= 1'b0;
      fin_q         <= 1'b0;
      res_q.valid   <= 1'b0;
      res_q.prob    <= '0;
      res_q.status  <= STATUS_OK;
      i_q           <= '0;
      j_q           <= '0;
    end else begin
      fin_q       <= 1'b0;
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (store_i) begin
            if (wr_en) cnt_q <= cnt_q + SC_W'(1);
            else       ovf_q <= 1'b1;
            if (last_i) state_q <= S_CHECK;
            else        fin_q   <= 1'b1;
          end
        end
        S_CHECK: begin
          if (rank_x >= cnt_x) begin
            res_q.valid  <= 1'b1;
            res_q.prob   <= '0;
            res_q.status <= STATUS_RANK;
            fin_q        <= 1'b1;
            cnt_q        <= '0;
            ovf_q        <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            i_q     <= '0;
            state_q <= S_RDI;
          end
        end
        S_RDI: state_q <= S_LDI;
        S_LDI: begin
          vi_q    <= rd_q;
          j_q     <= '0;
          less_q  <= '0;
          eq_q    <= '0;
          state_q <= S_RDJ;
        end
        S_RDJ: state_q <= S_CMPJ;
        S_CMPJ: begin
          if (rd_q < vi_q)  less_q <= less_q + SC_W'(1);
          if (rd_q == vi_q) eq_q   <= eq_q + SC_W'(1);
          j_q <= j_q + SC_W'(1);
          if (j_q + SC_W'(1) == cnt_q) state_q <= S_EVAL;
          else                         state_q <= S_RDJ;
        end
        S_EVAL: begin
          // candidate covers the rank when its equal run straddles it
          if ((less_x <= rank_x) && (rank_x < span_x)) begin
            res_q.valid  <= 1'b1;
            res_q.prob   <= vi_q;
            res_q.status <= ovf_q ? STATUS_OVF : STATUS_OK;
            fin_q        <= 1'b1;
            cnt_q        <= '0;
            ovf_q        <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            i_q     <= i_q + SC_W'(1);
            state_q <= S_RDI;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign finish_o = fin_q;
  assign result_o = res_q;

endmodule

[src/beta_ancestry_rank_probability.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beta_ancestry_rank_probability
// Per-sample ancestry probability of a mutation pair with rank selection.
// ----------------------------------------------------------------------------
// Usage: drive the four read counts and last_sample_i and raise start while
// busy is low; the sample is taken at that edge. busy stays high until the
// sample is fully processed. For a sample marked last, done_o pulses for one
// cycle with ancestry_prob_o (q1.32, 2^32 is one) and status_o; the receiver
// cannot stall and must take it in that cycle. order_rank is written through
// the cfg channel (always ready); the user must do so only while the block is
// idle; the block itself does not enforce this. Special samples (a pair with
// no reads) finish without terms; others walk |alt_q-alt_p| + |ref_q-ref_p|
// terms: each term needs 11 reads on the single table port and a 30-step exp
// multiply loop. Rank selection on a last sample then runs over the one
// buffer port. Reset: the log-factorial table refills itself entry by entry
// while busy is held high.
// ----------------------------------------------------------------------------
module beta_ancestry_rank_probability import barp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [CNT_W-1:0]   alt_p_count_i,
  input  logic [CNT_W-1:0]   ref_p_count_i,
  input  logic [CNT_W-1:0]   alt_q_count_i,
  input  logic [CNT_W-1:0]   ref_q_count_i,
  input  logic               last_sample_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RANK_W-1:0]  cfg_data_i,
  output logic               done_o,
  output logic [PROB_W-1:0]  ancestry_prob_o,
  output logic [1:0]         status_o
);

  logic                    busy_q;
  logic                    last_q;
  logic [RANK_W-1:0]       order_rank_q;
  logic                    tab_ready;
  logic                    accept;
  logic [TAB_AW-1:0]       tab_addr;
  logic signed [TAB_W-1:0] tab_data;
  logic                    eng_done;
  logic [PROB_W-1:0]       eng_prob;
  logic                    sel_finish;
  sel_result_t             sel_res;
  sample_t                 sample;

  assign busy        = busy_q || !tab_ready;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign sample.alt_p = alt_p_count_i;
  assign sample.ref_p = ref_p_count_i;
  assign sample.alt_q = alt_q_count_i;
  assign sample.ref_q = ref_q_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      last_q       <= 1'b0;
      order_rank_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        last_q <= last_sample_i;
      end else if (sel_finish) begin
        busy_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) order_rank_q <= cfg_data_i;
    end
  end

  barp_lfact_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (tab_addr),
    .rd_data_o (tab_data),
    .ready_o   (tab_ready)
  );

  barp_term_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .sample_i  (sample),
    .rd_addr_o (tab_addr),
    .rd_data_i (tab_data),
    .done_o    (eng_done),
    .prob_o    (eng_prob)
  );

  barp_rank_select #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .store_i      (eng_done),
    .prob_i       (eng_prob),
    .last_i       (last_q),
    .order_rank_i (order_rank_q),
    .finish_o     (sel_finish),
    .result_o     (sel_res)
  );

  assign done_o          = sel_res.valid;
  assign ancestry_prob_o = sel_res.prob;
  assign status_o        = sel_res.status;

  a_done_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("result without a transaction in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_OK || status_o == STATUS_RANK ||
                status_o == STATUS_OVF))
    else $error("undefined status code");

  a_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_RANK) |-> (ancestry_prob_o == '0))
    else $error("rank error with nonzero probability");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (ancestry_prob_o <= ONE_Q32))
    else $error("probability above one");

  a_fill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tab_ready |-> busy)
    else $error("accepting while table fill runs");

endmodule
